// ===== src/pcd_pkg.sv =====
package pcd_pkg;

    localparam int SUM_W   = 48;
    localparam int ENTRY_W = 3 * SUM_W;
    localparam int DENS_W  = 63;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic [1:0] MODE_DEPOSIT = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [1:0] SP_ELECTRON  = 2'd0;
    localparam logic [1:0] SP_ION       = 2'd1;
    localparam logic [1:0] SP_CARBON    = 2'd2;
    localparam logic [1:0] SP_NONE      = 2'd3;

    localparam logic [IDX_W-1:0] REG_INV_CELL_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CHARGE_ELECTRON = 3'd1;
    localparam logic [IDX_W-1:0] REG_CHARGE_ION      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CHARGE_CARBON   = 3'd3;

    localparam logic [CFG_W-1:0] RST_INV_CELL_WIDTH  = 32'h0001_0000;
    localparam logic [CFG_W-1:0] RST_CHARGE_ELECTRON = 32'hFFFF_0000;
    localparam logic [CFG_W-1:0] RST_CHARGE_ION      = 32'h0001_0000;
    localparam logic [CFG_W-1:0] RST_CHARGE_CARBON   = 32'h0003_0000;

    // work classes handed from front to back
    typedef enum logic [2:0] {
        K_DEPOSIT = 3'd0,
        K_OFFGRID = 3'd1,
        K_READ    = 3'd2,
        K_RDNONE  = 3'd3,
        K_CLEAR   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  species;
        logic [15:0] weight;
        logic [23:0] position;
        logic [7:0]  cell_req;
    } item_t;

    function automatic logic [SUM_W-1:0] get_sum(logic [ENTRY_W-1:0] e, logic [1:0] sp);
        logic [SUM_W-1:0] r;
        case (sp)
            SP_ELECTRON: r = e[SUM_W-1:0];
            SP_ION:      r = e[2*SUM_W-1:SUM_W];
            default:     r = e[3*SUM_W-1:2*SUM_W];
        endcase
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] put_sum(logic [ENTRY_W-1:0] e, logic [1:0] sp,
                                                    logic [SUM_W-1:0] v);
        logic [ENTRY_W-1:0] r;
        r = e;
        case (sp)
            SP_ELECTRON: r[SUM_W-1:0]         = v;
            SP_ION:      r[2*SUM_W-1:SUM_W]   = v;
            default:     r[3*SUM_W-1:2*SUM_W] = v;
        endcase
        return r;
    endfunction

    // saturating add of a split weight onto a cell sum
    function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] s, logic [32:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(v);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

// ===== src/pic_charge_deposition_1d_top.sv =====
// One-dimensional cloud-in-cell charge deposition for three species.
//
// Input channel: drive mode/species/weight/position/cell_req with start high;
// the word is taken at a clock edge where start is high and busy is low.
// Words go into a two-entry queue; the grid engine behind it drains it.
// Result channel: done pulses for exactly one cycle with cell_out, the three
// densities, charge_density and dropped; the receiver cannot stall, so take
// the word in that cycle.
// The grid engine works one word at a time. Its memory has a read and a write
// port, and reads use one shared 32x32 multiplier with 8 steps per species;
// a clear sweeps every cell. In-grid deposits give no result; off-grid
// deposits and reads give one.
// Configuration: cfg_we with cfg_index/cfg_wdata writes one register per
// cycle; write only while the block is idle.
// Reset: registers load their defaults and the grid memory is swept to zero,
// cell by cell, with busy held high throughout that sweep.
module pic_charge_deposition_1d_top #(
    parameter int CELLS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic [1:0]                    species,
    input  logic [15:0]                   weight,
    input  logic [23:0]                   position,
    input  logic [7:0]                    cell_req,
    output logic                          done,
    output logic [7:0]                    cell_out,
    output logic [pcd_pkg::DENS_W-1:0]    electron_density,
    output logic [pcd_pkg::DENS_W-1:0]    ion_density,
    output logic [pcd_pkg::DENS_W-1:0]    carbon_density,
    output logic signed [63:0]            charge_density,
    output logic                          dropped,
    input  logic                          cfg_we,
    input  logic [pcd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]     cfg_wdata
);
    import pcd_pkg::*;

    logic [CFG_W-1:0] icw_reg, qe_reg, qi_reg, qc_reg;
    logic  push, pop, q_full, q_empty, clearing;
    item_t push_item, head_item;

    // hold configuration; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icw_reg <= RST_INV_CELL_WIDTH;
            qe_reg  <= RST_CHARGE_ELECTRON;
            qi_reg  <= RST_CHARGE_ION;
            qc_reg  <= RST_CHARGE_CARBON;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_CELL_WIDTH:  icw_reg <= cfg_wdata;
                REG_CHARGE_ELECTRON: qe_reg  <= cfg_wdata;
                REG_CHARGE_ION:      qi_reg  <= cfg_wdata;
                REG_CHARGE_CARBON:   qc_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: accept and classify each word
    pcd_front #(.CELLS(CELLS)) u_front (
        .start         (start),
        .mode          (mode),
        .species       (species),
        .weight        (weight),
        .position      (position),
        .cell_req      (cell_req),
        .q_full        (q_full),
        .back_clearing (clearing),
        .busy          (busy),
        .push          (push),
        .item          (push_item)
    );

    // decouple front and back
    pcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back: grid memory, deposit and density arithmetic
    pcd_back #(.CELLS(CELLS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_item        (head_item),
        .q_empty          (q_empty),
        .pop              (pop),
        .clearing         (clearing),
        .inv_cell_width   (icw_reg),
        .charge_electron  (qe_reg),
        .charge_ion       (qi_reg),
        .charge_carbon    (qc_reg),
        .done             (done),
        .cell_out         (cell_out),
        .electron_density (electron_density),
        .ion_density      (ion_density),
        .carbon_density   (carbon_density),
        .charge_density   (charge_density),
        .dropped          (dropped)
    );

endmodule

// ===== src/pcd_front.sv =====
module pcd_front #(
    parameter int CELLS = 256
) (
    input  logic              start,
    input  logic [1:0]        mode,
    input  logic [1:0]        species,
    input  logic [15:0]       weight,
    input  logic [23:0]       position,
    input  logic [7:0]        cell_req,
    input  logic              q_full,
    input  logic              back_clearing,
    output logic              busy,
    output logic              push,
    output pcd_pkg::item_t    item
);
    import pcd_pkg::*;

    logic accept;
    logic keep;

    assign busy   = q_full | back_clearing;
    assign accept = start & ~busy;

    // classify the word; ignored words never reach the queue
    always_comb
    begin
        keep          = 1'b1;
        item.kind     = K_CLEAR;
        item.species  = species;
        item.weight   = weight;
        item.position = position;
        item.cell_req = cell_req;
        unique case (mode)
            MODE_DEPOSIT:
            begin
                if (species == SP_NONE)
                    keep = 1'b0;
                else if (32'(position[23:16]) > 32'(CELLS - 2))
                    item.kind = K_OFFGRID;
                else
                    item.kind = K_DEPOSIT;
            end
            MODE_READ:
                item.kind = (32'(cell_req) < 32'(CELLS)) ? K_READ : K_RDNONE;
            MODE_CLEAR:
                item.kind = K_CLEAR;
            default:
                keep = 1'b0;
        endcase
    end

    assign push = accept & keep;

endmodule

// ===== src/pcd_queue.sv =====
module pcd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcd_pkg::item_t    push_item,
    input  logic              pop,
    output pcd_pkg::item_t    head_item,
    output logic              empty,
    output logic              full
);
    import pcd_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign empty     = (cnt_reg == 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/pcd_back.sv =====
module pcd_back #(
    parameter int CELLS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcd_pkg::item_t                head_item,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          clearing,
    input  logic [pcd_pkg::CFG_W-1:0]     inv_cell_width,
    input  logic [pcd_pkg::CFG_W-1:0]     charge_electron,
    input  logic [pcd_pkg::CFG_W-1:0]     charge_ion,
    input  logic [pcd_pkg::CFG_W-1:0]     charge_carbon,
    output logic                          done,
    output logic [7:0]                    cell_out,
    output logic [pcd_pkg::DENS_W-1:0]    electron_density,
    output logic [pcd_pkg::DENS_W-1:0]    ion_density,
    output logic [pcd_pkg::DENS_W-1:0]    carbon_density,
    output logic signed [63:0]            charge_density,
    output logic                          dropped
);
    import pcd_pkg::*;

    localparam int CW = $clog2(CELLS);

    typedef enum logic [8:0] {
        S_CLR  = 9'b0_0000_0001,
        S_IDLE = 9'b0_0000_0010,
        S_DEP0 = 9'b0_0000_0100,
        S_DEP1 = 9'b0_0000_1000,
        S_DEP2 = 9'b0_0001_0000,
        S_RD0  = 9'b0_0010_0000,
        S_RD1  = 9'b0_0100_0000,
        S_MUL  = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [2:0]    phase_reg;
    logic [1:0]    sp_reg;
    logic          done_reg;

    item_t              cur_reg;
    logic [32:0]        w0_reg, w1_reg;
    logic [SUM_W-1:0]   sums_reg [3];
    logic [DENS_W-1:0]  dens_reg [3];
    logic [63:0]        prod_reg;
    logic [79:0]        wide_reg;
    logic [94:0]        term_reg;
    logic signed [81:0] acc_reg;
    logic               end_reg;

    logic [ENTRY_W-1:0] mem [CELLS];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    logic [CW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata;

    logic [CW-1:0]      dep_ip, dep_ip1, rd_idx;
    logic [SUM_W-1:0]   sum_cur;
    logic [DENS_W-1:0]  dens_cur;
    logic [31:0]        q_cur, qmag;
    logic               qneg;
    logic [31:0]        mul_a, mul_b;
    logic [79:0]        shifted;
    logic [DENS_W-1:0]  dens_new;
    logic               acc_fits;
    logic signed [63:0] chg_sat;

    assign dep_ip   = CW'(cur_reg.position[23:16]);
    assign dep_ip1  = dep_ip + CW'(1);
    assign rd_idx   = CW'(cur_reg.cell_req);
    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign clearing = (state_reg == S_CLR);
    assign done     = done_reg;

    assign sum_cur  = sums_reg[sp_reg];
    assign dens_cur = dens_reg[sp_reg];
    assign q_cur    = (sp_reg == SP_ELECTRON) ? charge_electron :
                      (sp_reg == SP_ION)      ? charge_ion : charge_carbon;
    assign qneg     = q_cur[31];
    assign qmag     = qneg ? (~q_cur + 32'd1) : q_cur;
    assign mul_a    = phase_reg[2] ? qmag : inv_cell_width;

    always_comb
    begin
        case (phase_reg)
            3'd0:    mul_b = {8'b0, sum_cur[23:0]};
            3'd1:    mul_b = {8'b0, sum_cur[47:24]};
            3'd4:    mul_b = dens_cur[31:0];
            3'd5:    mul_b = {1'b0, dens_cur[62:32]};
            default: mul_b = '0;
        endcase
    end

    assign shifted  = end_reg ? (wide_reg >> 15) : (wide_reg >> 16);
    assign dens_new = (|shifted[79:63]) ? {DENS_W{1'b1}} : shifted[DENS_W-1:0];
    assign acc_fits = (&acc_reg[81:63]) | ~(|acc_reg[81:63]);
    assign chg_sat  = acc_fits ? acc_reg[63:0] :
                      (acc_reg[81] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}});

    // memory port control
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = dep_ip;
        raddr  = dep_ip;
        wdata  = '0;
        unique case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
                waddr  = clr_cnt_reg;
            end
            S_DEP1:
            begin
                mem_we = 1'b1;
                wdata  = put_sum(rdata_reg, cur_reg.species,
                                 add_sat(get_sum(rdata_reg, cur_reg.species), w0_reg));
                raddr  = dep_ip1;
            end
            S_DEP2:
            begin
                mem_we = 1'b1;
                waddr  = dep_ip1;
                wdata  = put_sum(rdata_reg, cur_reg.species,
                                 add_sat(get_sum(rdata_reg, cur_reg.species), w1_reg));
            end
            S_RD0:
                raddr = rd_idx;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
                if (clr_cnt_reg == CW'(CELLS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (!q_empty)
                begin
                    unique case (head_item.kind)
                        K_DEPOSIT:           state_next = S_DEP0;
                        K_READ:              state_next = S_RD0;
                        K_OFFGRID, K_RDNONE: state_next = S_OUT;
                        default:             state_next = S_CLR;
                    endcase
                end
            S_DEP0: state_next = S_DEP1;
            S_DEP1: state_next = S_DEP2;
            S_DEP2: state_next = S_IDLE;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_MUL;
            S_MUL:
                if (phase_reg == 3'd7 && sp_reg == SP_CARBON)
                    state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            phase_reg   <= 3'd0;
            sp_reg      <= SP_ELECTRON;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            if (state_reg == S_CLR)
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            else
                clr_cnt_reg <= '0;
            if (state_reg == S_MUL)
            begin
                phase_reg <= phase_reg + 3'd1;
                if (phase_reg == 3'd7)
                    sp_reg <= sp_reg + 2'd1;
            end
            else
            begin
                phase_reg <= 3'd0;
                sp_reg    <= SP_ELECTRON;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_item;
        if (state_reg == S_DEP0)
        begin
            w0_reg <= 33'(cur_reg.weight) * (33'h1_0000 - 33'(cur_reg.position[15:0]));
            w1_reg <= 33'(cur_reg.weight) * 33'(cur_reg.position[15:0]);
        end
        if (state_reg == S_RD1)
        begin
            sums_reg[0] <= get_sum(rdata_reg, SP_ELECTRON);
            sums_reg[1] <= get_sum(rdata_reg, SP_ION);
            sums_reg[2] <= get_sum(rdata_reg, SP_CARBON);
            end_reg     <= (rd_idx == '0) || (rd_idx == CW'(CELLS - 1));
            acc_reg     <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
            case (phase_reg)
                3'd1: wide_reg <= 80'(prod_reg);
                3'd2: wide_reg <= wide_reg + {prod_reg[55:0], 24'b0};
                3'd3: dens_reg[sp_reg] <= dens_new;
                3'd5: term_reg <= 95'(prod_reg);
                3'd6: term_reg <= term_reg + {prod_reg[62:0], 32'b0};
                3'd7: acc_reg  <= qneg ? acc_reg - $signed({3'b0, term_reg[94:16]})
                                       : acc_reg + $signed({3'b0, term_reg[94:16]});
                default: ;
            endcase
        end
        if (state_reg == S_OUT)
        begin
            if (cur_reg.kind == K_READ)
            begin
                cell_out         <= cur_reg.cell_req;
                electron_density <= dens_reg[0];
                ion_density      <= dens_reg[1];
                carbon_density   <= dens_reg[2];
                charge_density   <= chg_sat;
                dropped          <= 1'b0;
            end
            else
            begin
                cell_out         <= (cur_reg.kind == K_OFFGRID) ? cur_reg.position[23:16]
                                                                : cur_reg.cell_req;
                electron_density <= '0;
                ion_density      <= '0;
                carbon_density   <= '0;
                charge_density   <= '0;
                dropped          <= (cur_reg.kind == K_OFFGRID);
            end
        end
    end

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_OUT))
        else $error("result strobe without output state");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_MUL) |-> !mem_we)
        else $error("grid write outside clear or deposit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != S_IDLE)
        else $error("pop did not leave idle");

endmodule

// ===== test/pcd_checker.sv =====
`timescale 1ns / 1ps

// Watches the word and result channels of the deposition block, keeps its own
// copy of the grid and registers, and compares every result with the oldest
// predicted one.
module pcd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [1:0]                      species,
    input  logic [15:0]                     weight,
    input  logic [23:0]                     position,
    input  logic [7:0]                      cell_req,
    input  logic                            done,
    input  logic [7:0]                      cell_out,
    input  logic [pcd_pkg::DENS_W-1:0]      electron_density,
    input  logic [pcd_pkg::DENS_W-1:0]      ion_density,
    input  logic [pcd_pkg::DENS_W-1:0]      carbon_density,
    input  logic signed [63:0]              charge_density,
    input  logic                            dropped,
    input  logic                            cfg_we,
    input  logic [pcd_pkg::IDX_W-1:0]       cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              errors,
    output int                              pending
);
    import pcd_pkg::*;

    localparam int NCELL = 256;

    typedef struct {
        logic [7:0]        cell_idx;
        logic [DENS_W-1:0] dens_e;
        logic [DENS_W-1:0] dens_i;
        logic [DENS_W-1:0] dens_c;
        logic [63:0]       charge;
        logic              drop;
    } cell_result_t;

    cell_result_t      cell_results[$];
    logic [SUM_W-1:0]  weight_sums[3][NCELL];
    logic              cell_live[NCELL];
    logic [CFG_W-1:0]  inv_width;
    logic [CFG_W-1:0]  charge_of[3];

    initial begin
        errors = 0;
        inv_width = RST_INV_CELL_WIDTH;
        charge_of[0] = RST_CHARGE_ELECTRON;
        charge_of[1] = RST_CHARGE_ION;
        charge_of[2] = RST_CHARGE_CARBON;
        for (int c = 0; c < NCELL; c++) cell_live[c] = 1'b0;
    end

    assign pending = cell_results.size();

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    function automatic logic [DENS_W-1:0] density_from(logic [SUM_W-1:0] s, logic edge_cell);
        logic [79:0] p;
        p = {32'b0, s} * {48'b0, inv_width};
        p = edge_cell ? (p >> 15) : (p >> 16);
        return (p[79:63] != 0) ? {DENS_W{1'b1}} : p[62:0];
    endfunction

    function automatic logic signed [81:0] charge_share(logic [31:0] q, logic [DENS_W-1:0] d);
        logic [31:0]          m;
        logic [94:0]          p;
        logic signed [81:0]   t;
        m = q[31] ? (~q + 32'd1) : q;
        p = ({63'b0, m} * {32'b0, d}) >> 16;
        t = $signed({3'b0, p[78:0]});
        return q[31] ? -t : t;
    endfunction

    // Clear the cell on its first touch since the last grid clear.
    function automatic void wake_cell(int c);
        if (!cell_live[c]) begin
            for (int s = 0; s < 3; s++) weight_sums[s][c] = '0;
            cell_live[c] = 1'b1;
        end
    endfunction

    function automatic void deposit_word();
        int          ip;
        logic [32:0] lo_part;
        logic [32:0] hi_part;
        cell_result_t r;
        ip = int'(position[23:16]);
        if (species == SP_NONE) return;
        if (ip > NCELL - 2) begin
            r = '{cell_idx: ip[7:0], dens_e: '0, dens_i: '0, dens_c: '0, charge: '0,
                  drop: 1'b1};
            cell_results.push_back(r);
            return;
        end
        lo_part = {17'b0, weight} * (33'd65536 - {17'b0, position[15:0]});
        hi_part = {17'b0, weight} * {17'b0, position[15:0]};
        wake_cell(ip);
        wake_cell(ip + 1);
        weight_sums[species][ip]     = add_sat(weight_sums[species][ip], lo_part);
        weight_sums[species][ip + 1] = add_sat(weight_sums[species][ip + 1], hi_part);
    endfunction

    function automatic void read_word();
        cell_result_t        r;
        logic [DENS_W-1:0]   d[3];
        logic signed [81:0]  acc;
        logic                edge_cell;
        r = '{cell_idx: cell_req, dens_e: '0, dens_i: '0, dens_c: '0, charge: '0,
              drop: 1'b0};
        if (cell_live[cell_req]) begin
            edge_cell = (cell_req == 0) || (cell_req == NCELL - 1);
            acc = '0;
            for (int s = 0; s < 3; s++) begin
                d[s] = density_from(weight_sums[s][cell_req], edge_cell);
                acc += charge_share(charge_of[s], d[s]);
            end
            r.dens_e = d[0];
            r.dens_i = d[1];
            r.dens_c = d[2];
            if (acc > 82'sh7FFF_FFFF_FFFF_FFFF)
                r.charge = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (acc < -82'sh8000_0000_0000_0000)
                r.charge = 64'h8000_0000_0000_0000;
            else
                r.charge = acc[63:0];
        end
        cell_results.push_back(r);
    endfunction

    always @(posedge clk) begin
        cell_result_t w;
        if (rst_n) begin
            // results first: a word taken at this edge cannot have produced one yet
            if (done) begin
                if (cell_results.size() == 0) begin
                    report("unexpected result", {56'b0, cell_out}, '0);
                end else begin
                    w = cell_results.pop_front();
                    if (cell_out !== w.cell_idx)
                        report("cell_out", 64'(cell_out), 64'(w.cell_idx));
                    if (electron_density !== w.dens_e)
                        report("electron_density", 64'(electron_density), 64'(w.dens_e));
                    if (ion_density !== w.dens_i)
                        report("ion_density", 64'(ion_density), 64'(w.dens_i));
                    if (carbon_density !== w.dens_c)
                        report("carbon_density", 64'(carbon_density), 64'(w.dens_c));
                    if (charge_density !== w.charge)
                        report("charge_density", 64'(charge_density), w.charge);
                    if (dropped !== w.drop) report("dropped", 64'(dropped), 64'(w.drop));
                end
            end
            if (start && !busy) begin
                case (mode)
                    MODE_DEPOSIT: deposit_word();
                    MODE_READ:    read_word();
                    MODE_CLEAR:   for (int c = 0; c < NCELL; c++) cell_live[c] = 1'b0;
                    default:      ;
                endcase
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_INV_CELL_WIDTH:  inv_width = cfg_wdata;
                    REG_CHARGE_ELECTRON: charge_of[0] = cfg_wdata;
                    REG_CHARGE_ION:      charge_of[1] = cfg_wdata;
                    REG_CHARGE_CARBON:   charge_of[2] = cfg_wdata;
                    default:             ;
                endcase
            end
        end
    end

endmodule

// ===== test/pic_charge_deposition_1d_top_tb.sv =====
`timescale 1ns / 1ps

module pic_charge_deposition_1d_top_tb;
    import pcd_pkg::*;

    // mode code the block must ignore
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // register index the block must ignore
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
    // cycles without any traffic before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // longest silent stretch: a grid clear plus margin
    localparam int DRAIN_CYCLES = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           mode = MODE_SPARE;
    logic [1:0]           species = SP_ELECTRON;
    logic [15:0]          weight = '0;
    logic [23:0]          position = '0;
    logic [7:0]           cell_req = '0;
    logic                 done;
    logic [7:0]           cell_out;
    logic [DENS_W-1:0]    electron_density;
    logic [DENS_W-1:0]    ion_density;
    logic [DENS_W-1:0]    carbon_density;
    logic signed [63:0]   charge_density;
    logic                 dropped;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    int                   errors;
    int                   pending;
    int                   quiet_cycles = 0;
    // sender idling switch; off during the no-gap stretch
    bit                   idle_on = 1'b1;

    pic_charge_deposition_1d_top dut (.*);

    pcd_checker u_checker (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    // Watchdog: count cycles in which no word moves on any channel.
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it; then maybe idle.
    task automatic send_word(logic [1:0] md, logic [1:0] sp, logic [15:0] w,
                             logic [23:0] pos, logic [7:0] cell_idx);
        mode     <= md;
        species  <= sp;
        weight   <= w;
        position <= pos;
        cell_req <= cell_idx;
        start    <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        // idle after about 12 words in a hundred
        if (idle_on && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop start and wait for every result, then for work that yields none.
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(logic [31:0] icw, logic [31:0] qe, logic [31:0] qi,
                             logic [31:0] qc);
        write_reg(REG_INV_CELL_WIDTH, icw);
        write_reg(REG_CHARGE_ELECTRON, qe);
        write_reg(REG_CHARGE_ION, qi);
        write_reg(REG_CHARGE_CARBON, qc);
    endtask

    // Random words around a small window of cells so reads hit live sums.
    task automatic random_phase(int count, bit pause_mid);
        int          base;
        int          r;
        logic [15:0] w;
        base = $urandom_range(0, 250);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            w = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
            if ($urandom_range(0, 39) == 0) base = $urandom_range(0, 250);
            if (pause_mid && n == count / 2) drain();
            if (r < 55)
                send_word(MODE_DEPOSIT, 2'($urandom_range(0, 2)), w,
                          {8'(base + $urandom_range(0, 4)), 16'($urandom)}, 8'($urandom));
            else if (r < 62)
                send_word(MODE_DEPOSIT, 2'($urandom), w, 24'($urandom), 8'($urandom));
            else if (r < 90)
                send_word(MODE_READ, 2'($urandom), w, 24'($urandom),
                          8'(base + $urandom_range(0, 5)));
            else if (r < 94)
                send_word(MODE_READ, 2'($urandom), w, 24'($urandom), 8'($urandom));
            else if (r < 95)
                send_word(MODE_CLEAR, 2'($urandom), w, 24'($urandom), 8'($urandom));
            else if (r < 97)
                send_word(MODE_READ, 2'($urandom), w, 24'($urandom),
                          $urandom_range(0, 1) ? 8'd0 : 8'd255);
            else
                send_word(MODE_SPARE, 2'($urandom), w, 24'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // hold off until the reset sweep of the grid is over
        while (busy) @(posedge clk);

        // Directed: field extremes, edge cells, off-grid, ignored codes, clear.
        send_word(MODE_DEPOSIT, SP_ELECTRON, 16'hFFFF, 24'h00_0000, 8'd0);
        send_word(MODE_DEPOSIT, SP_ION, 16'h0100, 24'h00_8000, 8'd0);
        send_word(MODE_DEPOSIT, SP_CARBON, 16'hFFFF, 24'h00_FFFF, 8'd0);
        send_word(MODE_DEPOSIT, SP_ELECTRON, 16'hFFFF, 24'hFE_FFFF, 8'd0);
        send_word(MODE_DEPOSIT, SP_CARBON, 16'h8001, 24'hFE_0001, 8'd0);
        send_word(MODE_DEPOSIT, SP_ION, 16'hFFFF, 24'hFF_1234, 8'd0);
        send_word(MODE_DEPOSIT, SP_NONE, 16'hFFFF, 24'h05_0000, 8'd0);
        send_word(MODE_DEPOSIT, SP_ELECTRON, 16'h0000, 24'h01_0000, 8'd0);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd0);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd1);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd2);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd254);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd255);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd100);
        send_word(MODE_SPARE, SP_CARBON, 16'hFFFF, 24'hFF_FFFF, 8'd255);
        send_word(MODE_CLEAR, SP_ELECTRON, 16'h0, 24'h0, 8'd0);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd0);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd255);
        send_word(MODE_DEPOSIT, SP_ION, 16'h1234, 24'h7F_4000, 8'd0);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd128);
        send_word(MODE_READ, SP_ELECTRON, 16'h0, 24'h0, 8'd127);

        random_phase(250, 1'b0);

        // Extremes: widest scale, most negative and most positive charges.
        drain();
        load_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        idle_on = 1'b0;
        random_phase(250, 1'b1);
        idle_on = 1'b1;

        // Zero scale: every density must read zero.
        drain();
        load_regs(32'h0000_0000, $urandom, $urandom, $urandom);
        random_phase(200, 1'b0);

        // Fully random registers; an unused index must change nothing.
        drain();
        load_regs($urandom, $urandom, $urandom, $urandom);
        write_reg(REG_SPARE, $urandom);
        random_phase(250, 1'b0);

        drain();
        load_regs(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        random_phase(250, 1'b1);

        drain();
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/pcd_pkg.sv
src/pcd_front.sv
src/pcd_queue.sv
src/pcd_back.sv
src/pic_charge_deposition_1d_top.sv
test/pcd_checker.sv
test/pic_charge_deposition_1d_top_tb.sv
